[hw/rtl/ial_pkg.sv]
// ial_pkg: shared types and constants for the indexed array list.
// Holds field widths, operation and status codes, and the check result struct.
// Used by indexed_array_list, ial_opcheck and ial_check.
`default_nettype none

package ial_pkg;

	localparam int DATA_W    = 32;
	localparam int CNT_W     = 7;
	localparam int OP_W      = 2;
	localparam int ST_W      = 2;
	localparam int IAL_DEPTH = 64;
	localparam int CNT_MAX   = (2 ** CNT_W) - 1;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_READ   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// Outcome of the admission check on one operation
	typedef struct packed {
		status_t status;
		logic    go;
	} check_t;

endpackage

`default_nettype wire

[hw/rtl/ial_opcheck.sv]
// ial_opcheck: admission check for one list operation.
// Decides full, empty and index-out-of-range against the current count and capacity.
// Depends on ial_pkg.
`default_nettype none

module ial_opcheck import ial_pkg::*; #(
	parameter int DEPTH = IAL_DEPTH
) (
	input  op_t              operation,
	input  logic [CNT_W-1:0] position,
	input  logic [CNT_W-1:0] entry_count,
	input  logic [CNT_W-1:0] capacity,
	output check_t           check
);

	localparam int LIMIT = (DEPTH < CNT_MAX) ? DEPTH : CNT_MAX;
	localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);

	logic full;
	logic empty;

	// Effective capacity is the smaller of the register and the store depth
	assign full  = (entry_count >= capacity) || (entry_count >= LIMIT_C);
	assign empty = (entry_count == '0);

	// Full wins over range on insert; empty wins over range on remove and read
	always_comb begin
		check.status = ST_OK;
		check.go     = 1'b0;
		unique case (operation) inside
			OP_INSERT: begin
				if (full) begin
					check.status = ST_FULL;
				end else if (position > entry_count) begin
					check.status = ST_RANGE;
				end else begin
					check.go = 1'b1;
				end
			end
			OP_REMOVE, OP_READ: begin
				if (empty) begin
					check.status = ST_EMPTY;
				end else if (position >= entry_count) begin
					check.status = ST_RANGE;
				end else begin
					check.go = 1'b1;
				end
			end
			OP_NOP: begin
				check.go = 1'b0;
			end
			default: begin
				check.go = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/indexed_array_list.sv]
// indexed_array_list: ordered list of signed 32-bit words in a single-port-pair store.
// Depends on ial_pkg and ial_opcheck.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one operation per beat: insert,
//   remove or read at a list position. Output channel (out_valid/out_stall)
//   returns one beat per operation: status, data word and the count after it.
//   capacity_we/capacity_wdata set the capacity register; write it only idle.
// Sequencing: insert shifts the entries from the position up, then writes the value;
//   remove and read fetch the entry, and remove then shifts the later entries down;
//   a failed or no-op operation goes straight to FIN, which loads the result.
//   One operation is in flight at a time; in_stall is high from the accept edge
//   until the result is loaded, so the next beat is taken in the cycle after that.
//   Each shifted entry takes a read state and a write state on the one
//   memory port pair, walked by the pointer adders under the sequencer.
// Reset clears the count, sets capacity to 64 and drops out_valid; the store
//   itself is not cleared. A stalled result holds in the output register; the
//   next operation runs meanwhile and waits at its end until that beat leaves.
`default_nettype none

module indexed_array_list import ial_pkg::*; #(
	parameter int DEPTH = IAL_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     capacity_we,
	input  logic [CNT_W-1:0]         capacity_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [OP_W-1:0]          operation,
	input  logic [CNT_W-1:0]         position,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [ST_W-1:0]          status,
	output logic signed [DATA_W-1:0] data_out,
	output logic [CNT_W-1:0]         count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [2:0] {
		IDLE,
		INS_RD,
		INS_WR,
		INS_PUT,
		FETCH,
		RM_RD,
		RM_WR,
		FIN
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    cap_q;
	logic [CNT_W-1:0]    ptr_q;
	op_t                 op_q;
	logic [CNT_W-1:0]    pos_q;
	logic [DATA_W-1:0]   val_q;
	logic [DATA_W-1:0]   data_q;
	status_t             res_status_q;
	logic                out_valid_q;
	status_t             out_status_q;
	logic [DATA_W-1:0]   out_data_q;
	logic [CNT_W-1:0]    out_count_q;

	logic [DATA_W-1:0]   mem_q [DEPTH];
	logic [DATA_W-1:0]   rd_q;

	logic [CNT_W-1:0]    ptr_dn;
	logic [CNT_W-1:0]    ptr_up;
	logic [CNT_W-1:0]    ptr_up2;
	logic [AW-1:0]       raddr;
	logic [AW-1:0]       waddr;
	logic [DATA_W-1:0]   wdata;
	logic                mem_we;
	op_t                 op_in;
	check_t              chk;

	assign op_in = op_t'(operation);

	// Admission check on the incoming beat
	ial_opcheck #(
		.DEPTH(DEPTH)
	) u_opcheck (
		.operation  (op_in),
		.position   (position),
		.entry_count(cnt_q),
		.capacity   (cap_q),
		.check      (chk)
	);

	// Pointer adders for both shift directions
	assign ptr_dn  = ptr_q - CNT_W'(1);
	assign ptr_up  = ptr_q + CNT_W'(1);
	assign ptr_up2 = ptr_q + CNT_W'(2);

	// Steer the memory port pair from the sequencer state
	always_comb begin
		raddr  = AW'(ptr_q);
		waddr  = AW'(ptr_q);
		wdata  = rd_q;
		mem_we = 1'b0;
		unique case (state_q)
			IDLE:    raddr = AW'(position);
			INS_RD:  raddr = AW'(ptr_dn);
			RM_RD:   raddr = AW'(ptr_up);
			INS_WR:  mem_we = 1'b1;
			RM_WR:   mem_we = 1'b1;
			INS_PUT: begin
				mem_we = 1'b1;
				waddr  = AW'(pos_q);
				wdata  = val_q;
			end
			default: mem_we = 1'b0;
		endcase
	end

	// Store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	// Sequencer: admit, shift one entry per read and write state pair, then hand off the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			cnt_q        <= '0;
			cap_q        <= CAP_RESET;
			ptr_q        <= '0;
			op_q         <= OP_NOP;
			pos_q        <= '0;
			val_q        <= '0;
			data_q       <= '0;
			res_status_q <= ST_OK;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_data_q   <= '0;
			out_count_q  <= '0;
		end else begin
			if (capacity_we) begin
				cap_q <= capacity_wdata;
			end
			// Drop the result once the receiver takes it; in FIN a new one loads instead
			if (out_valid_q && !out_stall && (state_q != FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						op_q         <= op_in;
						pos_q        <= position;
						val_q        <= value;
						res_status_q <= chk.status;
						data_q       <= '0;
						if (!chk.go) begin
							state_q <= FIN;
						end else begin
							unique case (op_in) inside
								OP_INSERT: begin
									ptr_q   <= cnt_q;
									state_q <= (position == cnt_q) ? INS_PUT : INS_RD;
								end
								OP_REMOVE, OP_READ: begin
									ptr_q   <= position;
									state_q <= FETCH;
								end
								default:            state_q <= FIN;
							endcase
						end
					end
				end
				INS_RD: begin
					state_q <= INS_WR;
				end
				INS_WR: begin
					ptr_q   <= ptr_dn;
					state_q <= (ptr_dn == pos_q) ? INS_PUT : INS_RD;
				end
				INS_PUT: begin
					data_q  <= val_q;
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= FIN;
				end
				FETCH: begin
					data_q <= rd_q;
					if (op_q == OP_READ) begin
						state_q <= FIN;
					end else if (ptr_up == cnt_q) begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= FIN;
					end else begin
						state_q <= RM_RD;
					end
				end
				RM_RD: begin
					state_q <= RM_WR;
				end
				RM_WR: begin
					ptr_q <= ptr_up;
					if (ptr_up2 == cnt_q) begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= FIN;
					end else begin
						state_q <= RM_RD;
					end
				end
				FIN: begin
					// Hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_data_q   <= data_q;
						out_count_q  <= cnt_q;
						state_q      <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != IDLE);
	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign data_out  = out_data_q;
	assign count     = out_count_q;

endmodule

`default_nettype wire

[hw/rtl/ial_check.sv]
// ial_check: port-level assertions for indexed_array_list, with its bind.
// Depends on ial_pkg; attaches to the top level through a bind statement.
`default_nettype none

module ial_check import ial_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [ST_W-1:0]          status,
	input logic signed [DATA_W-1:0] data_out,
	input logic [CNT_W-1:0]         count
);

	// A stalled result beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_out) && $stable(status)
			&& $stable(count))
		else $error("stalled result changed");

	// Any accepted operation keeps the input side busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after an accept");

	// A failed operation carries a zero data word
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> data_out == '0)
		else $error("failed operation returned nonzero data");

	// Empty is reported only with a zero count
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EMPTY) |-> count == '0)
		else $error("empty status with nonzero count");

endmodule

bind indexed_array_list ial_check u_ial_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.status   (status),
	.data_out (data_out),
	.count    (count)
);

`default_nettype wire

[verif/tb_top.sv]
// tb_top: self-checking bench for indexed_array_list, with directed and random operations.
// Depends on ial_pkg and the indexed_array_list RTL. A shadow list predicts every
// result beat; the driver and the monitor run as clocked blocks beside it.
module tb_top;
	import ial_pkg::*;

	// One pending operation beat
	typedef struct {
		logic [OP_W-1:0]          op;
		logic [CNT_W-1:0]         pos;
		logic signed [DATA_W-1:0] val;
	} list_op_t;

	// One predicted result beat
	typedef struct {
		status_t                  st;
		logic signed [DATA_W-1:0] data;
		logic [CNT_W-1:0]         cnt;
	} list_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     capacity_we = 1'b0;
	logic [CNT_W-1:0]         capacity_wdata = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [OP_W-1:0]          operation = '0;
	logic [CNT_W-1:0]         position = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [ST_W-1:0]          status;
	logic signed [DATA_W-1:0] data_out;
	logic [CNT_W-1:0]         count;

	list_op_t     op_backlog[$];
	list_result_t due_results[$];
	list_result_t due_res;
	list_op_t     cur_op;

	// Shadow list state
	logic signed [DATA_W-1:0] shadow_mem [IAL_DEPTH];
	logic [CNT_W-1:0]         shadow_len = '0;
	logic [CNT_W-1:0]         shadow_cap = CAP_RESET;

	// Generator-side tracking, used to aim positions at the live range
	int gen_len = 0;
	int gen_cap = 64;

	int  err_count = 0;
	int  in_idle_pct = 0;
	int  out_idle_pct = 0;
	int  in_gap = 0;
	int  out_gap = 0;
	logic in_taken = 1'b0;

	indexed_array_list DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.capacity_we    (capacity_we),
		.capacity_wdata (capacity_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.position       (position),
		.value          (value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.data_out       (data_out),
		.count          (count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		if (err_count < 50)
			$display("[%0t] ERROR %s", $time, what);
		err_count++;
	endtask

	// Apply one operation to the shadow list and return the result it yields
	function automatic list_result_t list_apply(op_t op, logic [CNT_W-1:0] pos,
			logic signed [DATA_W-1:0] val);
		list_result_t r;
		int           lim;
		int           i;
		r.st = ST_OK;
		r.data = '0;
		lim = (shadow_cap < IAL_DEPTH) ? shadow_cap : IAL_DEPTH;
		case (op)
			OP_INSERT: begin
				if (shadow_len >= lim)
					r.st = ST_FULL;
				else if (pos > shadow_len)
					r.st = ST_RANGE;
				else begin
					for (i = shadow_len; i > pos; i--)
						shadow_mem[i] = shadow_mem[i-1];
					shadow_mem[pos] = val;
					shadow_len = shadow_len + 1'b1;
					r.data = val;
				end
			end
			OP_REMOVE: begin
				if (shadow_len == 0)
					r.st = ST_EMPTY;
				else if (pos >= shadow_len)
					r.st = ST_RANGE;
				else begin
					r.data = shadow_mem[pos];
					for (i = pos + 1; i < shadow_len; i++)
						shadow_mem[i-1] = shadow_mem[i];
					shadow_len = shadow_len - 1'b1;
				end
			end
			OP_READ: begin
				if (shadow_len == 0)
					r.st = ST_EMPTY;
				else if (pos >= shadow_len)
					r.st = ST_RANGE;
				else
					r.data = shadow_mem[pos];
			end
			default: ;
		endcase
		r.cnt = shadow_len;
		return r;
	endfunction

	// Check result beats, predict accepted operation beats, track register writes
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (due_results.size() == 0)
				report_mismatch("result beat with no operation waiting");
			else begin
				due_res = due_results.pop_front();
				if (status !== due_res.st)
					report_mismatch($sformatf("status %0d, want %0d", status, due_res.st));
				if (data_out !== due_res.data)
					report_mismatch($sformatf("data_out %0d, want %0d", data_out,
						due_res.data));
				if (count !== due_res.cnt)
					report_mismatch($sformatf("count %0d, want %0d", count, due_res.cnt));
			end
		end
		if (arst_n && capacity_we)
			shadow_cap = capacity_wdata;
		if (arst_n && in_valid && !in_stall)
			due_results.push_back(list_apply(op_t'(operation), position, value));
	end

	// Drive operation beats: hold while stalled, insert idle bursts, else advance
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_taken) begin
			// hold the stalled beat
		end else if (in_gap != 0) begin
			in_gap <= in_gap - 1;
			in_valid <= 1'b0;
		end else if (in_idle_pct != 0 && $urandom_range(99, 0) < in_idle_pct) begin
			in_gap <= $urandom_range(5, 0);
			in_valid <= 1'b0;
		end else if (op_backlog.size() != 0) begin
			cur_op = op_backlog.pop_front();
			in_valid <= 1'b1;
			operation <= cur_op.op;
			position <= cur_op.pos;
			value <= cur_op.val;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Stall the result side in random bursts
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (out_gap != 0) begin
			out_gap <= out_gap - 1;
			out_stall <= 1'b1;
		end else if (out_idle_pct != 0 && $urandom_range(99, 0) < out_idle_pct) begin
			out_gap <= $urandom_range(5, 0);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Queue one operation and follow the count it leaves behind
	task automatic queue_op(input logic [OP_W-1:0] op, input logic [CNT_W-1:0] pos,
			input logic signed [DATA_W-1:0] val);
		list_op_t it;
		int       lim;
		it.op = op;
		it.pos = pos;
		it.val = val;
		op_backlog.push_back(it);
		lim = (gen_cap < IAL_DEPTH) ? gen_cap : IAL_DEPTH;
		if (op == OP_INSERT && gen_len < lim && pos <= gen_len)
			gen_len++;
		else if (op == OP_REMOVE && gen_len > 0 && pos < gen_len)
			gen_len--;
	endtask

	// Wait until every queued beat is sent and every result has come back;
	// sample at the rising edge, after the driver's updates have settled
	task automatic wait_idle();
		while (op_backlog.size() != 0 || in_valid || due_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_capacity(input int c);
		@(negedge clk);
		capacity_wdata <= CNT_W'(c);
		capacity_we <= 1'b1;
		@(negedge clk);
		capacity_we <= 1'b0;
		gen_cap = c;
	endtask

	// Random operations, mostly at live positions, with some noise
	task automatic run_random(input int n, input int ins_pct);
		logic [OP_W-1:0]          op;
		logic [CNT_W-1:0]         pos;
		logic signed [DATA_W-1:0] val;
		int                       r;
		repeat (n) begin
			r = $urandom_range(99, 0);
			if (r < 3)
				op = OP_NOP;
			else if (r < 3 + ins_pct)
				op = OP_INSERT;
			else if ($urandom_range(9, 0) < 6)
				op = OP_REMOVE;
			else
				op = OP_READ;
			if ($urandom_range(9, 0) == 0)
				pos = CNT_W'($urandom_range(127, 0));
			else if (op == OP_INSERT)
				pos = CNT_W'($urandom_range(gen_len, 0));
			else if (gen_len == 0)
				pos = '0;
			else
				pos = CNT_W'($urandom_range(gen_len - 1, 0));
			case ($urandom_range(15, 0))
				0: val = 32'sh8000_0000;
				1: val = 32'sh7FFF_FFFF;
				2: val = '0;
				3: val = -32'sd1;
				default: val = $urandom;
			endcase
			queue_op(op, pos, val);
		end
	endtask

	task automatic new_phase(input int cap, input int in_pct, input int out_pct);
		wait_idle();
		set_capacity(cap);
		in_idle_pct = in_pct;
		out_idle_pct = out_pct;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty list, bad positions, extreme words, traversal, shifts
		in_idle_pct = 20;
		out_idle_pct = 20;
		queue_op(OP_READ, 0, 0);
		queue_op(OP_REMOVE, 0, 0);
		queue_op(OP_INSERT, 1, 5);
		queue_op(OP_INSERT, 127, 6);
		queue_op(OP_INSERT, 0, 32'sh8000_0000);
		queue_op(OP_INSERT, 1, 32'sh7FFF_FFFF);
		queue_op(OP_INSERT, 0, 0);
		queue_op(OP_INSERT, 1, -32'sd1);
		queue_op(OP_INSERT, 4, 32'sh1234_5678);
		for (int i = 0; i < 5; i++)
			queue_op(OP_READ, CNT_W'(i), $urandom);
		queue_op(OP_READ, 5, 0);
		queue_op(OP_READ, 127, 0);
		queue_op(OP_NOP, 127, $urandom);
		queue_op(OP_REMOVE, 5, 0);
		queue_op(OP_REMOVE, 64, 0);
		queue_op(OP_REMOVE, 2, 0);
		queue_op(OP_REMOVE, 3, 0);
		queue_op(OP_REMOVE, 0, 0);

		// Directed: full list, full tested before a bad position
		new_phase(2, 20, 20);
		queue_op(OP_INSERT, 0, 11);
		queue_op(OP_INSERT, 127, 12);
		queue_op(OP_READ, 1, 0);

		// Directed: capacity lowered below the count keeps the entries
		new_phase(1, 20, 20);
		queue_op(OP_INSERT, 0, 13);
		queue_op(OP_REMOVE, 0, 0);
		queue_op(OP_INSERT, 1, 14);
		queue_op(OP_REMOVE, 0, 0);
		queue_op(OP_INSERT, 0, 32'sh5A5A_A5A5);

		// Random phases over several capacities
		new_phase(64, 25, 25);
		run_random(250, 75);
		new_phase(64, 10, 40);
		run_random(200, 20);
		new_phase(1, 40, 10);
		run_random(120, 50);
		new_phase($urandom_range(63, 2), 0, 0);
		run_random(200, 55);
		wait_idle();
		new_phase((gen_len > 1) ? $urandom_range(gen_len - 1, 1) : 1, 30, 30);
		run_random(150, 50);
		new_phase(64, 15, 15);
		run_random(250, 60);
		new_phase(33, 50, 50);
		run_random(200, 45);

		// Last stretch without idling on either side
		new_phase(64, 0, 0);
		run_random(230, 55);

		wait_idle();
		repeat (160) @(posedge clk);
		if (err_count == 0)
			$display("indexed_array_list: match");
		else
			$display("indexed_array_list: mismatch");
		$finish;
	end

	// Stop a hung run
	initial begin
		#(12 * 3000000);
		$display("indexed_array_list: mismatch");
		$finish;
	end

endmodule
